[src/cpd_pkg.sv]
// ----------------------------------------------------------------------------
// cpd_pkg: shared constants and types of the change point detector
// Default widths, register indexes and reset values of the configuration.
// ----------------------------------------------------------------------------
package cpd_pkg;

  // Default datapath widths
  localparam int unsigned SAMPLE_BITS_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // Largest EWMA precision shift; larger settings saturate to it
  localparam int unsigned EWMA_MAX_SCALE = 16;

  // Shift register widths
  localparam int unsigned SCALE_W  = 5;
  localparam int unsigned WEIGHT_W = 4;

  // Configuration register index
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT_THR    = 3'd0,
    REG_CUSUM_THR    = 3'd1,
    REG_CUSUM_DRIFT  = 3'd2,
    REG_EWMA_THR     = 3'd3,
    REG_EWMA_SCALE   = 3'd4,
    REG_EWMA_WEIGHT  = 3'd5
  } cfg_reg_e;

  // Reset values (integer part of the CUSUM threshold, shifted up by FRAC_BITS)
  localparam int unsigned COUNT_THR_RST     = 10;
  localparam int unsigned CUSUM_THR_INT_RST = 10;
  localparam int unsigned EWMA_THR_RST      = 10;
  localparam int unsigned EWMA_SCALE_RST    = 4;
  localparam int unsigned EWMA_WEIGHT_RST   = 4;

endpackage

[src/cpd_cusum.sv]
// ----------------------------------------------------------------------------
// cusum_detector: non-parametric CUSUM detector
// Holds the running sum in fixed point, clamps at zero, saturates at all ones.
// ----------------------------------------------------------------------------
module cusum_detector #(
  parameter int unsigned SAMPLE_BITS = cpd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = cpd_pkg::FRAC_BITS_DEF,
  localparam int unsigned SUM_BITS   = SAMPLE_BITS + FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   update_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SUM_BITS-1:0]    threshold_i,
  input  logic [SUM_BITS-1:0]    drift_i,
  output logic                   alert_o,
  output logic [SUM_BITS-1:0]    value_o
);

  logic [SUM_BITS-1:0] sum_q, sum_d;
  logic [SUM_BITS:0]   total;
  logic [SUM_BITS:0]   excess;

  always_comb begin
    total  = {1'b0, sum_q} + {1'b0, sample_i, {FRAC_BITS{1'b0}}};
    excess = (total <= {1'b0, drift_i}) ? '0 : total - {1'b0, drift_i};
    // saturate on overflow past the sum width
    value_o = excess[SUM_BITS] ? '1 : excess[SUM_BITS-1:0];
    alert_o = value_o >= threshold_i;
    sum_d   = alert_o ? '0 : value_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (update_i) begin
      sum_q <= sum_d;
    end
  end

endmodule

[src/cpd_ewma.sv]
// ----------------------------------------------------------------------------
// ewma_detector: shift-form EWMA detector
// Updates the scaled average and reports |sample - average| with saturation.
// ----------------------------------------------------------------------------
module ewma_detector #(
  parameter int unsigned SAMPLE_BITS = cpd_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned ACC_BITS   = SAMPLE_BITS + cpd_pkg::EWMA_MAX_SCALE,
  localparam int unsigned WIDE_BITS  = ACC_BITS + (1 << cpd_pkg::WEIGHT_W)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          update_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic [SAMPLE_BITS-1:0]        threshold_i,
  input  logic [cpd_pkg::SCALE_W-1:0]   scale_i,
  input  logic [cpd_pkg::WEIGHT_W-1:0]  weight_i,
  output logic                          alert_o,
  output logic [SAMPLE_BITS-1:0]        difference_o
);

  logic [ACC_BITS-1:0]         acc_q, acc_d;
  logic [cpd_pkg::SCALE_W-1:0] scale;
  logic [ACC_BITS-1:0]         scaled;
  logic [WIDE_BITS-1:0]        mix;
  logic [WIDE_BITS-1:0]        mix_shr;
  logic [ACC_BITS-1:0]         acc_new;
  logic [ACC_BITS-1:0]         average;
  logic [ACC_BITS-1:0]         sample_ext;
  logic [ACC_BITS-1:0]         diff_full;

  always_comb begin
    scale = (scale_i > cpd_pkg::SCALE_W'(cpd_pkg::EWMA_MAX_SCALE))
          ? cpd_pkg::SCALE_W'(cpd_pkg::EWMA_MAX_SCALE) : scale_i;
    sample_ext = ACC_BITS'(sample_i);
    scaled     = sample_ext << scale;
    // acc * (2^w - 1) + scaled, then divide by 2^w
    mix     = (WIDE_BITS'(acc_q) << weight_i) - WIDE_BITS'(acc_q) + WIDE_BITS'(scaled);
    mix_shr = mix >> weight_i;
    // an empty average loads the sample directly
    acc_new = (acc_q == '0) ? scaled : mix_shr[ACC_BITS-1:0];
    average = acc_new >> scale;
    diff_full = (sample_ext >= average) ? sample_ext - average : average - sample_ext;
    difference_o = (|diff_full[ACC_BITS-1:SAMPLE_BITS]) ? '1 : diff_full[SAMPLE_BITS-1:0];
    alert_o = difference_o >= threshold_i;
    acc_d   = alert_o ? '0 : acc_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (update_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

[src/change_point_detector.sv]
// ----------------------------------------------------------------------------
// change_point_detector: count, CUSUM and EWMA change detectors on one stream
// Pipeline: input register, then result register, which drives the output port.
// Throughput: 1 sample per cycle while the output is not stalled; the CUSUM sum
//   and EWMA accumulator close their update loop combinationally, between the
//   input and result registers.
// Reset: asynchronous, active low; clears both pipeline stages, both detector
//   states and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module change_point_detector #(
  parameter int unsigned SAMPLE_BITS = cpd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = cpd_pkg::FRAC_BITS_DEF,
  localparam int unsigned SUM_BITS   = SAMPLE_BITS + FRAC_BITS,
  localparam int unsigned CFG_W      = SUM_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]                cfg_data_i,
  // sample input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            count_alert_o,
  output logic                            cusum_alert_o,
  output logic                            ewma_alert_o,
  output logic [SUM_BITS-1:0]             cusum_value_o,
  output logic [SAMPLE_BITS-1:0]          ewma_difference_o
);

  localparam logic [SUM_BITS-1:0] CusumThrRst =
    SUM_BITS'(cpd_pkg::CUSUM_THR_INT_RST) << FRAC_BITS;

  // Configuration registers
  logic [SAMPLE_BITS-1:0]         count_thr_q;
  logic [SUM_BITS-1:0]            cusum_thr_q;
  logic [SUM_BITS-1:0]            cusum_drift_q;
  logic [SAMPLE_BITS-1:0]         ewma_thr_q;
  logic [cpd_pkg::SCALE_W-1:0]    ewma_scale_q;
  logic [cpd_pkg::WEIGHT_W-1:0]   ewma_weight_q;

  // Input stage
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;

  // Result stage
  logic                   out_valid_q;
  logic                   count_alert_q;
  logic                   cusum_alert_q;
  logic                   ewma_alert_q;
  logic [SUM_BITS-1:0]    cusum_value_q;
  logic [SAMPLE_BITS-1:0] ewma_diff_q;

  // Detector outputs for the sample held in the input stage
  logic                   advance;
  logic                   count_alert;
  logic                   cusum_alert;
  logic                   ewma_alert;
  logic [SUM_BITS-1:0]    cusum_value;
  logic [SAMPLE_BITS-1:0] ewma_diff;

  // Register writes; unknown indexes drop the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_thr_q   <= SAMPLE_BITS'(cpd_pkg::COUNT_THR_RST);
      cusum_thr_q   <= CusumThrRst;
      cusum_drift_q <= '0;
      ewma_thr_q    <= SAMPLE_BITS'(cpd_pkg::EWMA_THR_RST);
      ewma_scale_q  <= cpd_pkg::SCALE_W'(cpd_pkg::EWMA_SCALE_RST);
      ewma_weight_q <= cpd_pkg::WEIGHT_W'(cpd_pkg::EWMA_WEIGHT_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cpd_pkg::REG_COUNT_THR:   count_thr_q   <= cfg_data_i[SAMPLE_BITS-1:0];
        cpd_pkg::REG_CUSUM_THR:   cusum_thr_q   <= cfg_data_i[SUM_BITS-1:0];
        cpd_pkg::REG_CUSUM_DRIFT: cusum_drift_q <= cfg_data_i[SUM_BITS-1:0];
        cpd_pkg::REG_EWMA_THR:    ewma_thr_q    <= cfg_data_i[SAMPLE_BITS-1:0];
        cpd_pkg::REG_EWMA_SCALE:  ewma_scale_q  <= cfg_data_i[cpd_pkg::SCALE_W-1:0];
        cpd_pkg::REG_EWMA_WEIGHT: ewma_weight_q <= cfg_data_i[cpd_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held sample when the result register is free or being drained.
  // The detector states update on the same edge, so the next sample sees them.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Payload only moves on a transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_sample_q <= sample_i;
    end
  end

  assign count_alert = s1_sample_q >= count_thr_q;

  cusum_detector #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_cusum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .update_i    (advance),
    .sample_i    (s1_sample_q),
    .threshold_i (cusum_thr_q),
    .drift_i     (cusum_drift_q),
    .alert_o     (cusum_alert),
    .value_o     (cusum_value)
  );

  ewma_detector #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ewma (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .update_i     (advance),
    .sample_i     (s1_sample_q),
    .threshold_i  (ewma_thr_q),
    .scale_i      (ewma_scale_q),
    .weight_i     (ewma_weight_q),
    .alert_o      (ewma_alert),
    .difference_o (ewma_diff)
  );

  // Result register: fill on advance, empty on an output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      count_alert_q <= count_alert;
      cusum_alert_q <= cusum_alert;
      ewma_alert_q  <= ewma_alert;
      cusum_value_q <= cusum_value;
      ewma_diff_q   <= ewma_diff;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign count_alert_o     = count_alert_q;
  assign cusum_alert_o     = cusum_alert_q;
  assign ewma_alert_o      = ewma_alert_q;
  assign cusum_value_o     = cusum_value_q;
  assign ewma_difference_o = ewma_diff_q;

endmodule

[src/cpd_checker.sv]
// ----------------------------------------------------------------------------
// cpd_checker: port-level checks of the change point detector
// Watches reset, backpressure and delivery timing on the top-level ports.
// ----------------------------------------------------------------------------
module cpd_checker #(
  parameter int unsigned SAMPLE_BITS = cpd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = cpd_pkg::FRAC_BITS_DEF,
  localparam int unsigned SUM_BITS   = SAMPLE_BITS + FRAC_BITS
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic                   count_alert_o,
  input logic                   cusum_alert_o,
  input logic                   ewma_alert_o,
  input logic [SUM_BITS-1:0]    cusum_value_o,
  input logic [SAMPLE_BITS-1:0] ewma_difference_o
);

  // no result shows once reset has been seen at an edge
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_alert_o)
      && $stable(cusum_alert_o) && $stable(ewma_alert_o)
      && $stable(cusum_value_o) && $stable(ewma_difference_o))
    else $error("stalled result changed");

  // input side only stalls when the output side is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // an accepted sample is followed by a valid result on the output
  a_delivery: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("accepted sample did not produce a result");

endmodule

bind change_point_detector cpd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .FRAC_BITS   (FRAC_BITS)
) u_cpd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .count_alert_o     (count_alert_o),
  .cusum_alert_o     (cusum_alert_o),
  .ewma_alert_o      (ewma_alert_o),
  .cusum_value_o     (cusum_value_o),
  .ewma_difference_o (ewma_difference_o)
);

[tb/tb_change_point_detector.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_change_point_detector: self-checking bench for the change point detector
// Streams directed and random count samples through the block under changing
// register settings, predicts every result in the bench and checks each
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_change_point_detector;
  import cpd_pkg::*;

  localparam int unsigned SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int unsigned FRAC_W   = FRAC_BITS_DEF;
  localparam int unsigned SUM_W    = SAMPLE_W + FRAC_W;
  localparam int unsigned ACC_W    = SAMPLE_W + EWMA_MAX_SCALE;
  localparam logic [63:0] SUM_MAX    = (64'd1 << SUM_W) - 64'd1;
  localparam logic [63:0] SAMPLE_MAX = (64'd1 << SAMPLE_W) - 64'd1;

  // Indexes with no register behind them; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_B = 3'd7;

  localparam int unsigned CLK_HALF        = 5;
  localparam int unsigned RESET_CYCLES    = 7;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned PHASE_SAMPLES   = 110;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  // Settle time after a drain; the block has two register stages
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam longint unsigned WATCHDOG_NS = 1_000_000;

  typedef struct packed {
    logic                count_alert;
    logic                cusum_alert;
    logic                ewma_alert;
    logic [SUM_W-1:0]    cusum_value;
    logic [SAMPLE_W-1:0] ewma_difference;
  } verdict_t;

  // Clock, reset and DUT ports; every input starts at a known value
  logic                 clk   = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SUM_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  sample    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 count_alert;
  logic                 cusum_alert;
  logic                 ewma_alert;
  logic [SUM_W-1:0]     cusum_value;
  logic [SAMPLE_W-1:0]  ewma_difference;

  // Bench-side copy of the register file, loaded with the reset defaults
  logic [SAMPLE_W-1:0]  count_thr_q  = SAMPLE_W'(COUNT_THR_RST);
  logic [SUM_W-1:0]     cusum_thr_q  = SUM_W'(CUSUM_THR_INT_RST) << FRAC_W;
  logic [SUM_W-1:0]     drift_q      = '0;
  logic [SAMPLE_W-1:0]  ewma_thr_q   = SAMPLE_W'(EWMA_THR_RST);
  logic [SCALE_W-1:0]   scale_q      = SCALE_W'(EWMA_SCALE_RST);
  logic [WEIGHT_W-1:0]  weight_q     = WEIGHT_W'(EWMA_WEIGHT_RST);

  // Bench-side copy of the detector state
  logic [SUM_W-1:0]     cusum_sum_q  = '0;
  logic [ACC_W-1:0]     ewma_acc_q   = '0;

  logic [SAMPLE_W-1:0]  pending[$];    // samples waiting for an input transfer
  verdict_t             expected[$];   // predicted results, oldest first
  int unsigned          tx_idle_pct = 10;
  int unsigned          rx_idle_pct = 71;
  logic                 rx_hold     = 1'b0;
  bit                   hold_armed  = 1'b0;
  int unsigned          failures    = 0;

  change_point_detector DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .sample_i          (sample),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .count_alert_o     (count_alert),
    .cusum_alert_o     (cusum_alert),
    .ewma_alert_o      (ewma_alert),
    .cusum_value_o     (cusum_value),
    .ewma_difference_o (ewma_difference)
  );

  always #(CLK_HALF) clk = ~clk;

  // Advance the three detectors by one sample and return what the block
  // must report for it. The CUSUM and EWMA alerts each clear their own detector afterwards.
  function automatic verdict_t score_sample(input logic [SAMPLE_W-1:0] x);
    verdict_t    v;
    logic [63:0] total;
    logic [63:0] sum;
    logic [63:0] scaled;
    logic [63:0] acc;
    logic [63:0] avg;
    logic [63:0] diff;
    int unsigned f;
    int unsigned w;

    v.count_alert = (x >= count_thr_q);

    // CUSUM: clamp at zero on the way down, saturate at all ones on the way up
    total = {24'd0, cusum_sum_q} + ({40'd0, x} << FRAC_W);
    sum   = (total <= {24'd0, drift_q}) ? 64'd0 : total - {24'd0, drift_q};
    if (sum > SUM_MAX) begin
      sum = SUM_MAX;
    end
    v.cusum_value = sum[SUM_W-1:0];
    v.cusum_alert = (sum[SUM_W-1:0] >= cusum_thr_q);
    cusum_sum_q   = v.cusum_alert ? '0 : sum[SUM_W-1:0];

    // EWMA: an all-zero accumulator means no average yet, so load directly
    f      = (scale_q > EWMA_MAX_SCALE) ? EWMA_MAX_SCALE : int'(scale_q);
    w      = int'(weight_q);
    scaled = {40'd0, x} << f;
    acc    = {24'd0, ewma_acc_q};
    if (acc == 64'd0) begin
      acc = scaled;
    end else begin
      acc = ((acc << w) - acc + scaled) >> w;
    end
    ewma_acc_q = acc[ACC_W-1:0];
    avg  = {24'd0, ewma_acc_q} >> f;
    diff = ({40'd0, x} >= avg) ? {40'd0, x} - avg : avg - {40'd0, x};
    if (diff > SAMPLE_MAX) begin
      diff = SAMPLE_MAX;
    end
    v.ewma_difference = diff[SAMPLE_W-1:0];
    v.ewma_alert      = (diff[SAMPLE_W-1:0] >= ewma_thr_q);
    if (v.ewma_alert) begin
      ewma_acc_q = '0;
    end
    return v;
  endfunction

  // Write one register and mirror it; only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SUM_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_COUNT_THR:   count_thr_q = value[SAMPLE_W-1:0];
      REG_CUSUM_THR:   cusum_thr_q = value;
      REG_CUSUM_DRIFT: drift_q     = value;
      REG_EWMA_THR:    ewma_thr_q  = value[SAMPLE_W-1:0];
      REG_EWMA_SCALE:  scale_q     = value[SCALE_W-1:0];
      REG_EWMA_WEIGHT: weight_q    = value[WEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every queued sample is transferred and every result checked,
  // then let the pipeline settle. Sample on the falling edge to stay clear
  // of the driver and monitor.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending.size() != 0 || in_valid || expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One random phase: fresh settings around a random traffic baseline, then
  // mostly baseline samples with bursts, zeros and full-range noise mixed in.
  task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                              input bit squeeze);
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] x;
    int unsigned         pick;

    base = SAMPLE_W'($urandom_range(0, 500));
    write_reg(REG_COUNT_THR, SUM_W'(base) + SUM_W'($urandom_range(0, 2000)));
    write_reg(REG_CUSUM_THR, (SUM_W'($urandom_range(1, 4000)) << FRAC_W)
                             | SUM_W'($urandom_range(0, 65535)));
    write_reg(REG_CUSUM_DRIFT, (SUM_W'(base + $urandom_range(0, 60)) << FRAC_W)
                               | SUM_W'($urandom_range(0, 65535)));
    write_reg(REG_EWMA_THR, SUM_W'($urandom_range(0, 300)));
    // Keep the unused upper data bits noisy; the shifts see only their low bits
    write_reg(REG_EWMA_SCALE, SUM_W'({$urandom(), $urandom()}));
    write_reg(REG_EWMA_WEIGHT, SUM_W'({$urandom(), $urandom()}));
    write_reg($urandom_range(0, 1) ? UNMAPPED_IDX_A : UNMAPPED_IDX_B,
              SUM_W'({$urandom(), $urandom()}));

    @(negedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (PHASE_SAMPLES) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        x = base + SAMPLE_W'($urandom_range(0, 40));
      end else if (pick < 70) begin
        x = base * SAMPLE_W'($urandom_range(2, 12)) + SAMPLE_W'($urandom_range(0, 255));
      end else if (pick < 80) begin
        x = '0;
      end else if (pick < 90) begin
        x = SAMPLE_W'($urandom_range(0, 5000));
      end else begin
        x = SAMPLE_W'($urandom());
      end
      pending.push_back(x);
    end
    // Start the receiver hold-off while the sender still has plenty queued
    if (squeeze) begin
      hold_armed = 1'b1;
    end
    drain();
  endtask

  // Sender: predict on every input transfer, then offer the next sample
  // unless this cycle idles. Valid holds until its transfer.
  always @(posedge clk) begin : sample_driver
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected.push_back(score_sample(sample));
      end
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          sample   <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transfer against the oldest prediction,
  // then pick ready for the next cycle.
  always @(posedge clk) begin : result_monitor
    verdict_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected.size() == 0) begin
          $error("result transfer with no sample outstanding");
          failures++;
        end else begin
          want = expected.pop_front();
          if (count_alert !== want.count_alert) begin
            $error("count_alert: expected %0d, got %0d", want.count_alert, count_alert);
            failures++;
          end
          if (cusum_alert !== want.cusum_alert) begin
            $error("cusum_alert: expected %0d, got %0d", want.cusum_alert, cusum_alert);
            failures++;
          end
          if (ewma_alert !== want.ewma_alert) begin
            $error("ewma_alert: expected %0d, got %0d", want.ewma_alert, ewma_alert);
            failures++;
          end
          if (cusum_value !== want.cusum_value) begin
            $error("cusum_value: expected %0d, got %0d", want.cusum_value, cusum_value);
            failures++;
          end
          if (ewma_difference !== want.ewma_difference) begin
            $error("ewma_difference: expected %0d, got %0d",
                   want.ewma_difference, ewma_difference);
            failures++;
          end
        end
      end
      out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Long receiver stall: the block fills up and must push back on its input
  initial begin : receiver_hold_off
    wait (hold_armed);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $error("run did not complete in time");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int unsigned p;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults. Lead with zeros so the average stays empty, step the
    // count detector just below and at its level, push the CUSUM to exactly
    // its threshold with 1+2+3+4, and hit the largest sample.
    @(negedge clk);
    pending = '{24'd0, 24'd0, 24'd9, 24'd10, 24'hFFFFFF, 24'd1, 24'd2, 24'd3, 24'd4,
                24'd12, 24'd5};
    drain();

    // Zero thresholds alert on every sample; zero weight tracks the latest sample
    write_reg(REG_COUNT_THR, '0);
    write_reg(REG_CUSUM_THR, '0);
    write_reg(REG_EWMA_THR, '0);
    write_reg(REG_EWMA_WEIGHT, '0);
    @(negedge clk);
    pending = '{24'd0, 24'd7, 24'hFFFFFF};
    drain();

    // Top thresholds and widest shifts: full-scale samples overflow the sum
    // and it must saturate, landing exactly on the threshold
    write_reg(REG_COUNT_THR, '1);
    write_reg(REG_CUSUM_THR, '1);
    write_reg(REG_EWMA_THR, '1);
    write_reg(REG_EWMA_SCALE, SUM_W'(EWMA_MAX_SCALE));
    write_reg(REG_EWMA_WEIGHT, '1);
    @(negedge clk);
    pending = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1, 24'h800000};
    drain();

    // Drop the scale under a loaded accumulator so the difference saturates;
    // the largest drift keeps the sum clamped at zero
    write_reg(REG_CUSUM_DRIFT, '1);
    write_reg(REG_EWMA_SCALE, '0);
    write_reg(REG_EWMA_WEIGHT, SUM_W'(1));
    @(negedge clk);
    pending = '{24'd100, 24'd5};
    drain();

    // Scale codes above the maximum act as the maximum
    write_reg(REG_EWMA_SCALE, '1);
    write_reg(UNMAPPED_IDX_A, '1);
    @(negedge clk);
    pending = '{24'd3000, 24'd0, 24'd3000};
    drain();

    // Random phases: sender light and receiver heavy idling, then swapped,
    // then none, with the long receiver stall in the first of those
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 4) begin
        random_phase(10, 71, 1'b0);
      end else if (p < 7) begin
        random_phase(71, 10, 1'b0);
      end else begin
        random_phase(0, 0, p == 7);
      end
    end

    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
